### design/vhbp_pkg.sv
// Package for the versioned header byte parser.
// Holds the field codes, header layout constants and the state and result structs.
// Used by vhbp_step and versioned_header_byte_parser_top; depends on nothing.
package vhbp_pkg;

  // Field identifiers carried on field_id.
  localparam logic [2:0] FID_LENGTH  = 3'd0;
  localparam logic [2:0] FID_VERSION = 3'd1;
  localparam logic [2:0] FID_TYPE    = 3'd2;
  localparam logic [2:0] FID_REQUEST = 3'd3;
  localparam logic [2:0] FID_CRC     = 3'd4;
  localparam logic [2:0] FID_DEVICE  = 3'd5;
  localparam logic [2:0] FID_USER    = 3'd6;
  localparam logic [2:0] FID_NAME    = 3'd7;

  // Header byte positions.
  localparam logic [5:0] POS_START       = 6'd0;
  localparam logic [5:0] POS_LENGTH_END  = 6'd4;
  localparam logic [5:0] POS_VERSION     = 6'd5;
  localparam logic [5:0] POS_TYPE_END    = 6'd7;
  localparam logic [5:0] POS_REQUEST     = 6'd8;
  localparam logic [5:0] POS_SHORT_CRC   = 6'd10;
  localparam logic [5:0] POS_LONG_CRC    = 6'd12;
  localparam logic [5:0] POS_DEVICE_END  = 6'd14;
  localparam logic [5:0] POS_NAME_START  = 6'd15;
  localparam logic [5:0] POS_USER_END    = 6'd18;

  // Header lengths for the fixed layouts.
  localparam logic [5:0] LEN_VERSION_ZERO = 6'd11;
  localparam logic [5:0] LEN_LONG_CRC     = 6'd13;
  localparam logic [5:0] LEN_USER_ID      = 6'd19;

  // Version codes that select the layout.
  localparam logic [7:0] VER_ZERO     = 8'd0;
  localparam logic [7:0] VER_USER_ID  = 8'd1;
  localparam logic [7:0] VER_LONG_CRC = 8'h05;

  // Parser state carried between bytes.
  typedef struct packed {
    logic [5:0]  byte_position;
    logic [31:0] field_accumulator;
    logic [7:0]  version_seen;
    logic        header_complete;
  } vhbp_state_t;

  // One result beat.
  typedef struct packed {
    logic        field_valid;
    logic [2:0]  field_id;
    logic [31:0] field_value;
    logic [4:0]  name_index;
    logic        header_done;
    logic [5:0]  header_length;
    logic        truncated;
  } vhbp_result_t;

endpackage

### design/vhbp_step.sv
// Next-state and result logic of the parser for one message byte.
// Purely combinational; uses the types and constants of vhbp_pkg.
module vhbp_step #(
  parameter int NAME_BYTES = 20
) (
  input  vhbp_pkg::vhbp_state_t  state_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_byte_i,
  output vhbp_pkg::vhbp_state_t  state_o,
  output vhbp_pkg::vhbp_result_t result_o,
  output logic                   emit_o
);
  import vhbp_pkg::*;

  localparam logic [5:0] NameLastPos = 6'(15 + NAME_BYTES - 1);
  localparam logic [5:0] NameHdrLen  = 6'(15 + NAME_BYTES);

  logic [5:0]  pos;
  logic [31:0] acc_shift;
  logic [7:0]  ver;
  logic        have;
  logic        done;
  logic [2:0]  fid;
  logic [31:0] fval;
  logic [4:0]  nidx;
  logic [5:0]  hlen;

  assign pos       = state_i.byte_position;
  assign acc_shift = {state_i.field_accumulator[23:0], data_byte_i};
  assign ver       = (pos == POS_VERSION) ? data_byte_i : state_i.version_seen;

  // Decode which field, if any, this byte completes.
  always_comb begin
    have = 1'b0;
    done = 1'b0;
    fid  = FID_LENGTH;
    fval = '0;
    nidx = '0;
    hlen = '0;
    if (pos == POS_LENGTH_END) begin
      have = 1'b1; fid = FID_LENGTH; fval = acc_shift;
    end else if (pos == POS_VERSION) begin
      have = 1'b1; fid = FID_VERSION; fval = {24'd0, data_byte_i};
    end else if (pos == POS_TYPE_END) begin
      have = 1'b1; fid = FID_TYPE; fval = acc_shift;
    end else if (pos == POS_REQUEST) begin
      have = 1'b1; fid = FID_REQUEST; fval = {24'd0, data_byte_i};
    end else if (pos > POS_REQUEST) begin
      if (ver >= VER_LONG_CRC) begin
        if (pos == POS_LONG_CRC) begin
          have = 1'b1; fid = FID_CRC; fval = acc_shift;
          done = 1'b1; hlen = LEN_LONG_CRC;
        end
      end else if (pos == POS_SHORT_CRC) begin
        have = 1'b1; fid = FID_CRC; fval = acc_shift;
        if (ver == VER_ZERO) begin
          done = 1'b1; hlen = LEN_VERSION_ZERO;
        end
      end else if (pos == POS_DEVICE_END) begin
        have = 1'b1; fid = FID_DEVICE; fval = acc_shift;
      end else if (pos >= POS_NAME_START) begin
        if (ver == VER_USER_ID) begin
          if (pos == POS_USER_END) begin
            have = 1'b1; fid = FID_USER; fval = acc_shift;
            done = 1'b1; hlen = LEN_USER_ID;
          end
        end else begin
          have = 1'b1; fid = FID_NAME; fval = {24'd0, data_byte_i};
          nidx = 5'(pos - POS_NAME_START);
          if (pos == NameLastPos) begin
            done = 1'b1; hlen = NameHdrLen;
          end
        end
      end
    end
  end

  // Update the state and assemble the result beat.
  always_comb begin
    state_o  = state_i;
    result_o = '0;
    emit_o   = 1'b0;
    if (state_i.header_complete) begin
      // Trailing bytes are dropped; the last one rearms the parser.
      if (last_byte_i) begin
        state_o = '0;
      end
    end else begin
      state_o.field_accumulator = (pos == POS_START || have) ? 32'd0 : acc_shift;
      state_o.byte_position     = pos + 6'd1;
      state_o.version_seen      = ver;
      state_o.header_complete   = done;
      result_o.field_valid      = have;
      result_o.field_id         = have ? fid : 3'd0;
      result_o.field_value      = have ? fval : 32'd0;
      result_o.name_index       = (have && fid == FID_NAME) ? nidx : 5'd0;
      result_o.header_done      = done;
      result_o.header_length    = done ? hlen : 6'd0;
      if (last_byte_i) begin
        state_o            = '0;
        result_o.truncated = !done;
      end
      emit_o = have || result_o.truncated;
    end
  end

endmodule

### design/versioned_header_byte_parser_top.sv
// Throughput: one byte per cycle unless a byte with a result beat meets a blocked output;
// a byte sits in an input register while the parse step runs, and its result goes to an
// output register that parts the two sides.
// Reset (rst_ni low, asynchronous): parser state and both stages clear, no beat pending.
// Top level of the versioned header byte parser; depends on vhbp_pkg and vhbp_step.
module versioned_header_byte_parser_top #(
  parameter int NAME_BYTES = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        field_valid_o,
  output logic [2:0]  field_id_o,
  output logic [31:0] field_value_o,
  output logic [4:0]  name_index_o,
  output logic        header_done_o,
  output logic [5:0]  header_length_o,
  output logic        truncated_o
);
  import vhbp_pkg::*;

  localparam logic [5:0] NameHdrLen = 6'(15 + NAME_BYTES);

  logic         in_valid_q, in_valid_d;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  vhbp_state_t  state_q, state_d;
  vhbp_state_t  step_state;
  vhbp_result_t step_result;
  logic         step_emit;
  logic         out_valid_q, out_valid_d;
  vhbp_result_t out_q;
  logic         out_free;
  logic         in_fire;
  logic         in_accept;

  // Parse step for the byte held in the input register.
  vhbp_step #(
    .NAME_BYTES(NAME_BYTES)
  ) u_step (
    .state_i    (state_q),
    .data_byte_i(in_byte_q),
    .last_byte_i(in_last_q),
    .state_o    (step_state),
    .result_o   (step_result),
    .emit_o     (step_emit)
  );

  // Handshake: the held byte retires unless it has a beat and the output is blocked.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_fire    = in_valid_q && (!step_emit || out_free);
  assign in_stall_o = in_valid_q && !in_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept ? 1'b1 : (in_fire ? 1'b0 : in_valid_q);
  assign state_d     = in_fire ? step_state : state_q;
  assign out_valid_d = (in_fire && step_emit) ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // Payload registers for the input byte and the result beat.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
    if (in_fire && step_emit) begin
      out_q <= step_result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign field_valid_o   = out_q.field_valid;
  assign field_id_o      = out_q.field_id;
  assign field_value_o   = out_q.field_value;
  assign name_index_o    = out_q.name_index;
  assign header_done_o   = out_q.header_done;
  assign header_length_o = out_q.header_length;
  assign truncated_o     = out_q.truncated;

`ifndef NO_ASSERTIONS
  // A beat always carries a field or a truncation flag.
  a_beat_has_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (field_valid_o || truncated_o))
    else $error("result beat carries neither field nor truncation");

  // A completed header is never also truncated and always carries its last field.
  a_done_not_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && header_done_o) |-> (field_valid_o && !truncated_o))
    else $error("header_done with truncated or without field");

  // Header length takes one of the layout values.
  a_header_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && header_done_o) |->
      (header_length_o == LEN_VERSION_ZERO || header_length_o == LEN_LONG_CRC ||
       header_length_o == LEN_USER_ID || header_length_o == NameHdrLen))
    else $error("unexpected header length");

  // Name index is zero except on name bytes.
  a_name_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && field_id_o != FID_NAME) |-> (name_index_o == 5'd0))
    else $error("name index set on a non-name field");

  // The input side only stalls while a byte waits in the input register.
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked output");
`endif

endmodule

### verif/versioned_header_byte_parser_top_tb.sv
`timescale 1ns / 100ps
// Testbench for versioned_header_byte_parser_top: it drives whole and cut-short messages
// byte by byte and checks each result beat against a predictor kept in step with the bytes.
// Depends on vhbp_pkg and the design files under design/.
module versioned_header_byte_parser_top_tb;
  import vhbp_pkg::*;

  localparam int NAME_BYTES     = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        field_valid_o;
  logic [2:0]  field_id_o;
  logic [31:0] field_value_o;
  logic [4:0]  name_index_o;
  logic        header_done_o;
  logic [5:0]  header_length_o;
  logic        truncated_o;

  // Predicted parser state, advanced once per accepted byte.
  logic [5:0]  hdr_pos = '0;
  logic [31:0] hdr_acc = '0;
  logic [7:0]  hdr_version = '0;
  logic        hdr_complete = 1'b0;

  vhbp_result_t expected_beats[$];
  int           error_count = 0;
  int           bytes_sent = 0;
  int           stuck_cycles = 0;
  bit           idle_on = 1'b1;

  versioned_header_byte_parser_top #(
    .NAME_BYTES(NAME_BYTES)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .field_valid_o(field_valid_o),
    .field_id_o(field_id_o),
    .field_value_o(field_value_o),
    .name_index_o(name_index_o),
    .header_done_o(header_done_o),
    .header_length_o(header_length_o),
    .truncated_o(truncated_o)
  );

  // Clock: 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // The result side stalls at random while idling is enabled.
  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 24);
  end

  task automatic clear_parser();
    hdr_pos      = '0;
    hdr_acc      = '0;
    hdr_version  = '0;
    hdr_complete = 1'b0;
  endtask

  // Advance the predicted parser by one byte and queue the beat it causes, if any.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [5:0]   p;
    logic [31:0]  a;
    logic [7:0]   v;
    logic         have;
    logic         done;
    vhbp_result_t beat;
    beat = '0;
    have = 1'b0;
    done = 1'b0;
    // Bytes past a finished header are dropped; the last one rearms the parser.
    if (hdr_complete) begin
      if (last) clear_parser();
      return;
    end
    p = hdr_pos;
    a = {hdr_acc[23:0], b};
    v = (p == POS_VERSION) ? b : hdr_version;
    if (p == POS_START) begin
      a = '0;
    end else if (p == POS_LENGTH_END) begin
      have = 1'b1; beat.field_id = FID_LENGTH; beat.field_value = a;
    end else if (p == POS_VERSION) begin
      hdr_version = b;
      have = 1'b1; beat.field_id = FID_VERSION; beat.field_value = {24'd0, b};
    end else if (p == POS_TYPE_END) begin
      have = 1'b1; beat.field_id = FID_TYPE; beat.field_value = a;
    end else if (p == POS_REQUEST) begin
      have = 1'b1; beat.field_id = FID_REQUEST; beat.field_value = {24'd0, b};
    end else if (p > POS_REQUEST) begin
      // The version picks the layout of the rest of the header.
      if (v >= VER_LONG_CRC) begin
        if (p == POS_LONG_CRC) begin
          have = 1'b1; beat.field_id = FID_CRC; beat.field_value = a;
          done = 1'b1; beat.header_length = LEN_LONG_CRC;
        end
      end else if (p == POS_SHORT_CRC) begin
        have = 1'b1; beat.field_id = FID_CRC; beat.field_value = a;
        if (v == VER_ZERO) begin
          done = 1'b1; beat.header_length = LEN_VERSION_ZERO;
        end
      end else if (p == POS_DEVICE_END) begin
        have = 1'b1; beat.field_id = FID_DEVICE; beat.field_value = a;
      end else if (p >= POS_NAME_START) begin
        if (v == VER_USER_ID) begin
          if (p == POS_USER_END) begin
            have = 1'b1; beat.field_id = FID_USER; beat.field_value = a;
            done = 1'b1; beat.header_length = LEN_USER_ID;
          end
        end else begin
          have = 1'b1; beat.field_id = FID_NAME; beat.field_value = {24'd0, b};
          beat.name_index = 5'(p - POS_NAME_START);
          if (int'(p) == int'(POS_NAME_START) + NAME_BYTES - 1) begin
            done = 1'b1; beat.header_length = 6'(int'(POS_NAME_START) + NAME_BYTES);
          end
        end
      end
    end
    if (have) a = '0;
    hdr_acc = a;
    hdr_pos = p + 6'd1;
    if (done) hdr_complete = 1'b1;
    // A last byte before the header is complete marks the message truncated.
    if (last) begin
      beat.truncated = !done;
      clear_parser();
    end
    beat.field_valid = have;
    beat.header_done = done;
    if (have || beat.truncated) expected_beats.push_back(beat);
  endtask

  // Send one byte, with random idle cycles ahead of it, and wait until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    bit taken;
    while (idle_on && ($urandom_range(99) < 24)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    bytes_sent++;
    parse_byte(b, last);
  endtask

  // Random byte content that hits both extremes often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       pick_byte = 8'h00;
      1:       pick_byte = 8'hFF;
      default: pick_byte = 8'($urandom_range(255));
    endcase
  endfunction

  // One message of len bytes whose version byte is ver.
  task automatic send_message(input logic [7:0] ver, input int len);
    for (int i = 0; i < len; i++) begin
      send_byte((i == int'(POS_VERSION)) ? ver : pick_byte(), i == len - 1);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Compare every accepted beat with the oldest prediction; watch for a hang.
  always @(negedge clk_i) begin
    vhbp_result_t exp_beat;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: field_id 0x%0h, field_value 0x%0h",
                 field_id_o, field_value_o);
          error_count++;
        end else begin
          exp_beat = expected_beats.pop_front();
          check_field("field_valid", 32'(exp_beat.field_valid), 32'(field_valid_o));
          check_field("field_id", 32'(exp_beat.field_id), 32'(field_id_o));
          check_field("field_value", exp_beat.field_value, field_value_o);
          check_field("name_index", 32'(exp_beat.name_index), 32'(name_index_o));
          check_field("header_done", 32'(exp_beat.header_done), 32'(header_done_o));
          check_field("header_length", 32'(exp_beat.header_length), 32'(header_length_o));
          check_field("truncated", 32'(exp_beat.truncated), 32'(truncated_o));
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("** versioned_header_byte_parser_top: FAILED **");
        $finish;
      end
    end
  end

  // Corner messages: lone start byte, version 0 header ending on the last byte,
  // a cut at the length field and a cut at the version byte.
  task automatic test_directed();
    send_byte(8'hFF, 1'b1);
    for (int i = 0; i < 11; i++) begin
      send_byte((i == int'(POS_VERSION)) ? VER_ZERO : 8'hFF, i == 10);
    end
    for (int i = 0; i < 5; i++) begin
      send_byte(8'h00, i == 4);
    end
    for (int i = 0; i < 6; i++) begin
      send_byte((i == int'(POS_VERSION)) ? 8'hFF : 8'h5A, i == 5);
    end
  endtask

  // Mostly well-formed messages of every layout, some cut short, some noise.
  task automatic test_random_traffic(input int count);
    int         stop_at;
    int         kind;
    int         hlen;
    int         len;
    logic [7:0] ver;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(7))
        0:       ver = VER_ZERO;
        1:       ver = VER_USER_ID;
        2:       ver = 8'($urandom_range(2, 4));
        3:       ver = VER_LONG_CRC;
        4:       ver = 8'hFF;
        default: ver = 8'($urandom_range(255));
      endcase
      if (ver >= VER_LONG_CRC) hlen = int'(LEN_LONG_CRC);
      else if (ver == VER_ZERO) hlen = int'(LEN_VERSION_ZERO);
      else if (ver == VER_USER_ID) hlen = int'(LEN_USER_ID);
      else hlen = int'(POS_NAME_START) + NAME_BYTES;
      kind = $urandom_range(99);
      if (kind < 10) begin
        // Noise: random bytes with stray last flags, closed by a last byte.
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_byte(pick_byte(), (i == len - 1) || ($urandom_range(3) == 0));
        end
      end else if (kind < 30) begin
        send_message(ver, $urandom_range(1, hlen - 1));
      end else begin
        send_message(ver, hlen + $urandom_range(0, 3));
      end
    end
  endtask

  // A stretch with no idling on either side.
  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_traffic(200);
    idle_on = 1'b1;
  endtask

  // The sender holds off until every predicted beat has come out.
  task automatic test_drain_pause();
    test_random_traffic(60);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_beats.size() != 0);
    test_random_traffic(60);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_back_to_back();
    test_drain_pause();
    test_random_traffic(650);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** versioned_header_byte_parser_top: PASSED **");
    end else begin
      $display("** versioned_header_byte_parser_top: FAILED **");
    end
    $finish;
  end

endmodule
